// ===== design/pas_pkg.sv =====
// ============================================================================
// Priority aging scheduler package
// Shared table entry type, operation and status codes, priority limits.
// ============================================================================
`default_nettype none

package pas_pkg;

    // One ready-table entry as held in the table memory
    typedef struct packed {
        logic [7:0] id;
        logic [5:0] static_prio;
        logic [5:0] dynamic_prio;
        logic       user;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Operation codes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_PICK = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_PRIO = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    // Priority limits: request width and table width
    localparam logic signed [6:0] REQ_PRIO_MIN = -7'sd20;
    localparam logic signed [6:0] REQ_PRIO_MAX = 7'sd20;
    localparam logic signed [5:0] PRIO_MIN     = -6'sd20;

    localparam logic [7:0] QUANTUM_RESET = 8'd20;

endpackage

`default_nettype wire

// ===== design/pas_table_ram.sv =====
// ============================================================================
// Ready table memory
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module pas_table_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire                  clk,
    input  wire                  wr_en,
    input  wire [ADDR_W-1:0]     wr_addr,
    input  wire pas_pkg::entry_t wr_data,
    input  wire [ADDR_W-1:0]     rd_addr,
    output pas_pkg::entry_t      rd_data
);

    pas_pkg::entry_t mem [DEPTH];
    pas_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/priority_aging_scheduler.sv =====
// ============================================================================
// Priority aging scheduler
// Ready table of up to TASKS tasks in queue order with add, pick and tick.
// ============================================================================
// Add and tick requests finish in the cycle they are accepted. A pick walks the
// ready table twice through the single read port of the table memory: a scan
// pass that finds the winner (lowest dynamic priority, then lowest static
// priority, then nearest the queue head) and a compaction pass that ages every
// other entry by one step toward -20 and writes it back one slot lower where
// needed. One request is worked on at a time; a finished result sits in an
// output register, and a new request is taken while it waits if the request
// itself needs no result slot at once (a pick on a non-empty table).
// Write quantum_ticks only while the block is idle; it is loaded on each pick.
// The table memory needs no clearing after reset: a fill count marks the valid
// prefix, and only that prefix is ever read.
// ============================================================================
`default_nettype none

module priority_aging_scheduler #(
    parameter int TASKS = 16
) (
    input  wire               clk,
    input  wire               rst_n,

    input  wire               quantum_ticks_we,
    input  wire [7:0]         quantum_ticks,

    input  wire               in_valid,
    output logic              in_ready,
    input  wire [1:0]         operation,
    input  wire [7:0]         task_id,
    input  wire signed [6:0]  priority_req,
    input  wire               user_task,

    output logic              out_valid,
    input  wire               out_ready,
    output logic [1:0]        status,
    output logic [7:0]        chosen_id,
    output logic signed [5:0] chosen_priority,
    output logic              preempted
);

    localparam int IDX_W = $clog2(TASKS);
    localparam int CNT_W = $clog2(TASKS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TASKS);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_AGE  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic               rvalid_reg;
    logic [IDX_W-1:0]   ridx_reg;

    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    pas_pkg::entry_t    best_reg, best_next;

    logic               cur_valid_reg, cur_valid_next;
    logic [7:0]         cur_id_reg, cur_id_next;
    logic [5:0]         cur_prio_reg, cur_prio_next;
    logic               cur_user_reg, cur_user_next;
    logic [7:0]         quantum_left_reg, quantum_left_next;
    logic [7:0]         quantum_ticks_reg;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [7:0]         chosen_id_reg;
    logic [5:0]         chosen_prio_reg;
    logic               preempted_reg;

    logic               res_load;
    logic [1:0]         res_status;
    logic [7:0]         res_id;
    logic [5:0]         res_prio;
    logic               res_pre;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    pas_pkg::entry_t    wr_data;
    pas_pkg::entry_t    rd_data;

    logic               out_free;
    logic               accept;
    logic               issue;
    logic               table_full;
    logic               bad_prio;
    logic               better;
    pas_pkg::entry_t    aged;

    pas_table_ram #(
        .DEPTH  (TASKS),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign table_full = (count_reg == FULL_CNT);
    assign bad_prio   = (priority_req < pas_pkg::REQ_PRIO_MIN) ||
                        (priority_req > pas_pkg::REQ_PRIO_MAX);

    // A pick on a non-empty table needs no result slot until it finishes
    assign in_ready = (state_reg == S_IDLE) &&
                      (out_free || ((operation == pas_pkg::OP_PICK) && (count_reg != '0)));
    assign accept   = in_valid && in_ready;

    // Read the valid prefix during both table walks
    assign issue = ((state_reg == S_SCAN) || (state_reg == S_AGE)) &&
                   (rd_ptr_reg < count_reg);

    // Winner compare: strictly better only, so ties keep the earlier entry
    assign better = (ridx_reg == '0) ||
                    ($signed(rd_data.dynamic_prio) < $signed(best_reg.dynamic_prio)) ||
                    (($signed(rd_data.dynamic_prio) == $signed(best_reg.dynamic_prio)) &&
                     ($signed(rd_data.static_prio) < $signed(best_reg.static_prio)));

    // Age one step toward the floor
    always_comb
    begin
        aged = rd_data;
        if ($signed(rd_data.dynamic_prio) != pas_pkg::PRIO_MIN)
        begin
            aged.dynamic_prio = rd_data.dynamic_prio - 6'd1;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        best_idx_next     = best_idx_reg;
        best_next         = best_reg;
        cur_valid_next    = cur_valid_reg;
        cur_id_next       = cur_id_reg;
        cur_prio_next     = cur_prio_reg;
        cur_user_next     = cur_user_reg;
        quantum_left_next = quantum_left_reg;
        res_load          = 1'b0;
        res_status        = pas_pkg::STAT_OK;
        res_id            = '0;
        res_prio          = '0;
        res_pre           = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = count_reg[IDX_W-1:0];
        wr_data           = aged;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        pas_pkg::OP_ADD:
                        begin
                            res_load = 1'b1;
                            if (bad_prio)
                            begin
                                res_status = pas_pkg::STAT_BAD_PRIO;
                            end
                            else if (table_full)
                            begin
                                res_status = pas_pkg::STAT_FULL;
                            end
                            else
                            begin
                                // Append at the tail, dynamic priority starts at static
                                wr_en                = 1'b1;
                                wr_data.id           = task_id;
                                wr_data.static_prio  = priority_req[5:0];
                                wr_data.dynamic_prio = priority_req[5:0];
                                wr_data.user         = user_task;
                                count_next           = count_reg + 1'b1;
                            end
                        end
                        pas_pkg::OP_PICK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res_status = pas_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                rd_ptr_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        pas_pkg::OP_TICK:
                        begin
                            res_load = 1'b1;
                            if (!cur_valid_reg)
                            begin
                                if (quantum_left_reg != '0)
                                begin
                                    quantum_left_next = quantum_left_reg - 8'd1;
                                end
                            end
                            else
                            begin
                                res_id   = cur_id_reg;
                                res_prio = cur_prio_reg;
                                if ((quantum_left_reg == '0) && cur_user_reg)
                                begin
                                    if (table_full)
                                    begin
                                        // Hold the task as current
                                        res_status = pas_pkg::STAT_FULL;
                                    end
                                    else
                                    begin
                                        // Re-queue the expired user task at the tail
                                        wr_en                = 1'b1;
                                        wr_data.id           = cur_id_reg;
                                        wr_data.static_prio  = cur_prio_reg;
                                        wr_data.dynamic_prio = cur_prio_reg;
                                        wr_data.user         = 1'b1;
                                        count_next           = count_reg + 1'b1;
                                        cur_valid_next       = 1'b0;
                                        res_pre              = 1'b1;
                                    end
                                end
                                else if (quantum_left_reg != '0)
                                begin
                                    quantum_left_next = quantum_left_reg - 8'd1;
                                end
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (rvalid_reg && better)
                begin
                    best_idx_next = ridx_reg;
                    best_next     = rd_data;
                end
                if (!issue && !rvalid_reg)
                begin
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    state_next  = S_AGE;
                end
            end
            S_AGE:
            begin
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                // Drop the winner, compact and age the rest
                if (rvalid_reg && (ridx_reg != best_idx_reg))
                begin
                    wr_en       = 1'b1;
                    wr_addr     = wr_ptr_reg;
                    wr_data     = aged;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (!issue && !rvalid_reg)
                begin
                    count_next        = count_reg - 1'b1;
                    cur_valid_next    = 1'b1;
                    cur_id_next       = best_reg.id;
                    cur_prio_next     = best_reg.static_prio;
                    cur_user_next     = best_reg.user;
                    quantum_left_next = quantum_ticks_reg;
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res_id     = cur_id_reg;
                    res_prio   = cur_prio_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            rd_ptr_reg        <= '0;
            wr_ptr_reg        <= '0;
            rvalid_reg        <= 1'b0;
            cur_valid_reg     <= 1'b0;
            cur_id_reg        <= '0;
            cur_prio_reg      <= '0;
            cur_user_reg      <= 1'b0;
            quantum_left_reg  <= pas_pkg::QUANTUM_RESET;
            quantum_ticks_reg <= pas_pkg::QUANTUM_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            rvalid_reg       <= issue;
            cur_valid_reg    <= cur_valid_next;
            cur_id_reg       <= cur_id_next;
            cur_prio_reg     <= cur_prio_next;
            cur_user_reg     <= cur_user_next;
            quantum_left_reg <= quantum_left_next;
            if (quantum_ticks_we)
            begin
                quantum_ticks_reg <= quantum_ticks;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and walk bookkeeping, no reset needed
    always_ff @(posedge clk)
    begin
        ridx_reg     <= rd_ptr_reg[IDX_W-1:0];
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        if (res_load)
        begin
            status_reg      <= res_status;
            chosen_id_reg   <= res_id;
            chosen_prio_reg <= res_prio;
            preempted_reg   <= res_pre;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign chosen_id       = chosen_id_reg;
    assign chosen_priority = $signed(chosen_prio_reg);
    assign preempted       = preempted_reg;

endmodule

`default_nettype wire
